### hw/rtl/assert_macros.svh
// Assertion macros for the velocity setpoint RTL.
// Needs clk and rst in the scope of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### hw/rtl/mpvs_pkg.sv
// Shared widths, register indexes, constants and helpers for the velocity setpoint block.
// No dependencies.
package mpvs_pkg;

  localparam int ACC_W      = 66;
  localparam int MPL_W      = 21;
  localparam int DVD_W      = 56;
  localparam int DSR_W      = 20;
  localparam int SUM_W      = 48;
  localparam int ERR_W      = 32;
  localparam int DT_W       = 20;
  localparam int GAIN_W     = 16;
  localparam int IN_W       = 304;
  localparam int OUT_W      = 96;
  localparam int USER_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  localparam logic [DT_W-1:0]  MIN_DT      = 20'd1000;
  localparam logic [DSR_W-1:0] US_PER_S    = 20'd1000000;
  localparam logic [DSR_W-1:0] FORCE_SCALE = 20'd100;
  localparam logic [7:0]       HOLD_ANGLE  = 8'd90;

  localparam logic [CFG_IDX_W-1:0] REG_KP_XY  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_XY  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_XY  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_Z   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI_Z   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_Z   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS = 4'd7;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [SUM_W-1:0] esum_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  function automatic err_t sat32(input logic signed [63:0] v);
    err_t r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] clamp_lim(input logic signed [33:0] v,
                                            input logic [15:0] lim16);
    logic signed [33:0] hi;
    logic signed [33:0] r;
    hi = $signed({10'd0, lim16, 8'd0});
    r = v;
    if (r > hi) r = hi;
    if (r < -hi) r = -hi;
    return r[31:0];
  endfunction

endpackage

### hw/rtl/multi_axis_pid_velocity_setpoint.sv
// Multi-axis PID velocity setpoint: x/y/z/force PID, yaw rotation, hold latch, clamp.
// Depends on mpvs_pkg and assert_macros.svh.
//
// One request is one control tick; one result comes back per tick. The block works on one
// tick at a time, and takes longer when the force loop drives x. The time is set by a
// bit-serial multiply-accumulate unit (five products per axis and four for the rotation)
// and a restoring divider that retires one quotient bit per cycle (two divisions per axis
// plus one for force scaling). A finished result waits in the output register while the
// next tick is taken. Config writes are accepted every cycle.
`include "assert_macros.svh"

module multi_axis_pid_velocity_setpoint #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpvs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // target_x, target_y, target_z, target_force, grip_angle, measured_x, measured_y,
  // measured_z, measured_force, heading, elapsed_us, zero pad
  input  logic [mpvs_pkg::IN_W-1:0]         s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // vel_x, vel_y, vel_z
  output logic [mpvs_pkg::OUT_W-1:0]        m_tdata,
  // force_mode, hold_active
  output logic [mpvs_pkg::USER_W-1:0]       m_tuser
);
  import mpvs_pkg::*;

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int IDX_W   = SINE_TABLE_BITS - 1;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint Q30 = 64'sd1 << 30;
  localparam longint TermDiv [1:6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156};

  typedef logic [14:0] qtab_t [0:QUARTER];

  function automatic qtab_t build_qtab();
    qtab_t  t;
    longint x;
    longint term;
    longint sum_v;
    for (int r = 0; r <= QUARTER; r++) begin
      x = HalfPiQ30 * r / QUARTER;
      term = x;
      sum_v = x;
      for (int n = 1; n <= 6; n++) begin
        term = term * x / Q30;
        term = term * x / Q30;
        term = -term / TermDiv[n];
        sum_v = sum_v + term;
      end
      if (sum_v < 0) sum_v = 0;
      t[r] = 15'((sum_v * 16384 + (64'sd1 << 29)) >>> 30);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_ERR  = 5'd1;
  localparam logic [4:0] ST_MUL  = 5'd2;
  localparam logic [4:0] ST_DIV  = 5'd3;
  localparam logic [4:0] ST_INT  = 5'd4;
  localparam logic [4:0] ST_SUM  = 5'd5;
  localparam logic [4:0] ST_DRV  = 5'd6;
  localparam logic [4:0] ST_DER  = 5'd7;
  localparam logic [4:0] ST_KD   = 5'd8;
  localparam logic [4:0] ST_KI   = 5'd9;
  localparam logic [4:0] ST_PID  = 5'd10;
  localparam logic [4:0] ST_FX   = 5'd11;
  localparam logic [4:0] ST_TAB0 = 5'd12;
  localparam logic [4:0] ST_TAB1 = 5'd13;
  localparam logic [4:0] ST_TAB2 = 5'd14;
  localparam logic [4:0] ST_ROT1 = 5'd15;
  localparam logic [4:0] ST_ROT2 = 5'd16;
  localparam logic [4:0] ST_ROT3 = 5'd17;
  localparam logic [4:0] ST_ROT4 = 5'd18;
  localparam logic [4:0] ST_OUT  = 5'd19;

  localparam logic [4:0] MPL_LAST = 5'(MPL_W - 1);
  localparam logic [5:0] DVD_LAST = 6'(DVD_W - 1);

  logic [4:0] state;
  logic [4:0] ret;
  logic [1:0] ax;

  logic [GAIN_W-1:0] kp_xy, ki_xy, kd_xy, kp_z, ki_z, kd_z;
  logic [47:0] force_gains;
  logic [31:0] limits;

  err_t tgt [0:2];
  err_t meas [0:2];
  err_t held [0:2];
  err_t ftgt, fmeas;
  logic hold, hold_flag;
  logic [DT_W-1:0] dt;
  logic [SINE_TABLE_BITS-1:0] hk;

  err_t prior [0:3];
  esum_t esum [0:3];

  err_t e;
  esum_t ssave;
  logic signed [DVD_W:0] deriv;
  err_t lx, ly, lz;
  logic signed [33:0] vx_raw;

  acc_t acc, mcand;
  logic signed [MPL_W-1:0] mpl;
  logic [4:0] mcnt;

  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] rem, dsr;
  logic dneg;
  logic [5:0] dcnt;

  logic [14:0] rom_q;
  logic rom_neg;
  logic [IDX_W-1:0] rom_addr;
  logic [SINE_TABLE_BITS-1:0] rom_k;
  logic signed [15:0] sin_v, cos_v, rom_val;

  logic [31:0] vel_x, vel_y, vel_z;
  logic fmode_q, hold_q;

  // combinational helpers
  err_t tsel;
  logic signed [32:0] ediff;
  err_t e_new;
  logic [GAIN_W-1:0] kp_sel, ki_sel, kd_sel;
  logic signed [DVD_W:0] qs;
  logic signed [63:0] p64;
  logic signed [55:0] p56;
  logic signed [57:0] sum58;
  esum_t sum_sat;
  acc_t div_x, div_abs;
  logic [DSR_W-1:0] div_d;
  logic [DSR_W:0] r_sh;
  logic fits;
  logic signed [33:0] vy_raw;
  logic vz_ok;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign m_tdata   = {vel_z, vel_y, vel_x};
  assign m_tuser   = {hold_q, fmode_q};

  always_comb begin
    tsel = 32'sd0;
    if (ax == 2'd3) begin
      ediff = {fmeas[31], fmeas} - {ftgt[31], ftgt};
    end else begin
      tsel = hold ? held[ax] : tgt[ax];
      ediff = {tsel[31], tsel} - {meas[ax][31], meas[ax]};
    end
    e_new = sat32(64'(ediff));
  end

  always_comb begin
    case (ax)
      2'd0, 2'd1: begin
        kp_sel = kp_xy; ki_sel = ki_xy; kd_sel = kd_xy;
      end
      2'd2: begin
        kp_sel = kp_z; ki_sel = ki_z; kd_sel = kd_z;
      end
      default: begin
        kp_sel = force_gains[15:0]; ki_sel = force_gains[31:16]; kd_sel = force_gains[47:32];
      end
    endcase
  end

  always_comb begin
    qs = dneg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
    if (acc[65:63] == 3'b000 || acc[65:63] == 3'b111) p64 = acc[63:0];
    else if (acc[65]) p64 = {1'b1, 63'd0};
    else p64 = {1'b0, {63{1'b1}}};
    p56 = p64[63:8];
    sum58 = 58'(esum[ax]) + 58'(qs);
    if (sum58[57:47] == 11'd0 || sum58[57:47] == {11{1'b1}}) sum_sat = sum58[47:0];
    else if (sum58[57]) sum_sat = {1'b1, 47'd0};
    else sum_sat = {1'b0, {47{1'b1}}};
    vy_raw = acc[47:14];
  end

  always_comb begin
    case (state)
      ST_INT: begin
        div_x = acc; div_d = US_PER_S;
      end
      ST_DRV: begin
        div_x = acc; div_d = dt;
      end
      default: begin
        div_x = ACC_W'(p56); div_d = FORCE_SCALE;
      end
    endcase
    div_abs = div_x[ACC_W-1] ? -div_x : div_x;
    r_sh = {rem, dvd[DVD_W-1]};
    fits = (r_sh >= {1'b0, dsr});
  end

  // sine/cosine table, one registered read per cycle
  always_comb begin
    rom_k = (state == ST_TAB0) ? hk : hk + SINE_TABLE_BITS'(QUARTER);
    if (rom_k[SINE_TABLE_BITS-2])
      rom_addr = IDX_W'(QUARTER) - {1'b0, rom_k[SINE_TABLE_BITS-3:0]};
    else
      rom_addr = {1'b0, rom_k[SINE_TABLE_BITS-3:0]};
    rom_val = rom_neg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
  end

  always_ff @(posedge clk) begin
    rom_q <= QTAB[rom_addr];
    rom_neg <= rom_k[SINE_TABLE_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_xy <= '0; ki_xy <= '0; kd_xy <= '0;
      kp_z <= '0; ki_z <= '0; kd_z <= '0;
      force_gains <= '0;
      limits <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KP_XY:  kp_xy <= cfg_data[15:0];
        REG_KI_XY:  ki_xy <= cfg_data[15:0];
        REG_KD_XY:  kd_xy <= cfg_data[15:0];
        REG_KP_Z:   kp_z <= cfg_data[15:0];
        REG_KI_Z:   ki_z <= cfg_data[15:0];
        REG_KD_Z:   kd_z <= cfg_data[15:0];
        REG_FORCE:  force_gains <= cfg_data;
        REG_LIMITS: limits <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret <= ST_IDLE;
      ax <= 2'd0;
      m_tvalid <= 1'b0;
      hold_flag <= 1'b0;
      for (int i = 0; i < 3; i++) held[i] <= '0;
      for (int i = 0; i < 4; i++) begin
        prior[i] <= '0;
        esum[i] <= '0;
      end
      mcnt <= '0;
      dcnt <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            tgt[0] <= s_tdata[31:0];
            tgt[1] <= s_tdata[63:32];
            tgt[2] <= s_tdata[95:64];
            ftgt <= s_tdata[127:96];
            hold <= (s_tdata[135:128] >= HOLD_ANGLE);
            hold_flag <= (s_tdata[135:128] >= HOLD_ANGLE);
            if ((s_tdata[135:128] >= HOLD_ANGLE) && !hold_flag) begin
              held[0] <= s_tdata[167:136];
              held[1] <= s_tdata[199:168];
              held[2] <= s_tdata[231:200];
            end
            meas[0] <= s_tdata[167:136];
            meas[1] <= s_tdata[199:168];
            meas[2] <= s_tdata[231:200];
            fmeas <= s_tdata[263:232];
            hk <= s_tdata[279:280-SINE_TABLE_BITS];
            dt <= (s_tdata[299:280] < MIN_DT) ? MIN_DT : s_tdata[299:280];
            ax <= 2'd0;
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          e <= e_new;
          acc <= '0;
          mcand <= ACC_W'(e_new);
          mpl <= MPL_W'(dt);
          mcnt <= '0;
          ret <= ST_INT;
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mpl[0]) acc <= (mcnt == MPL_LAST) ? acc - mcand : acc + mcand;
          mcand <= mcand << 1;
          mpl <= mpl >>> 1;
          mcnt <= mcnt + 5'd1;
          if (mcnt == MPL_LAST) state <= ret;
        end
        ST_INT, ST_DRV: begin
          dvd <= div_abs[DVD_W-1:0];
          dneg <= div_x[ACC_W-1];
          dsr <= div_d;
          rem <= '0;
          dcnt <= '0;
          ret <= (state == ST_INT) ? ST_SUM : ST_DER;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= fits ? DSR_W'(r_sh - {1'b0, dsr}) : r_sh[DSR_W-1:0];
          dvd <= {dvd[DVD_W-2:0], fits};
          dcnt <= dcnt + 6'd1;
          if (dcnt == DVD_LAST) state <= ret;
        end
        ST_SUM: begin
          esum[ax] <= sum_sat;
          ssave <= sum_sat;
          prior[ax] <= e;
          acc <= '0;
          mcand <= ACC_W'(e) - ACC_W'(prior[ax]);
          mpl <= MPL_W'(US_PER_S);
          mcnt <= '0;
          ret <= ST_DRV;
          state <= ST_MUL;
        end
        ST_DER: begin
          deriv <= qs;
          acc <= '0;
          mcand <= ACC_W'(e);
          mpl <= MPL_W'(kp_sel);
          mcnt <= '0;
          ret <= ST_KD;
          state <= ST_MUL;
        end
        ST_KD: begin
          mcand <= ACC_W'(deriv);
          mpl <= MPL_W'(kd_sel);
          mcnt <= '0;
          ret <= ST_KI;
          state <= ST_MUL;
        end
        ST_KI: begin
          mcand <= ACC_W'(ssave);
          mpl <= MPL_W'(ki_sel);
          mcnt <= '0;
          ret <= ST_PID;
          state <= ST_MUL;
        end
        ST_PID: begin
          case (ax)
            2'd0: lx <= sat32(64'(p56));
            2'd1: ly <= sat32(64'(p56));
            2'd2: lz <= sat32(64'(p56));
            default: ;
          endcase
          if (ax != 2'd3) begin
            ax <= ax + 2'd1;
            state <= ST_ERR;
          end else if (fmeas[31]) begin
            // force mode: x command is force PID / 100
            dvd <= div_abs[DVD_W-1:0];
            dneg <= div_x[ACC_W-1];
            dsr <= div_d;
            rem <= '0;
            dcnt <= '0;
            ret <= ST_FX;
            state <= ST_DIV;
          end else begin
            state <= ST_TAB0;
          end
        end
        ST_FX: begin
          lx <= sat32(64'(qs));
          state <= ST_TAB0;
        end
        ST_TAB0: state <= ST_TAB1;
        ST_TAB1: begin
          sin_v <= rom_val;
          state <= ST_TAB2;
        end
        ST_TAB2: begin
          cos_v <= rom_val;
          state <= ST_ROT1;
        end
        ST_ROT1: begin
          acc <= '0;
          mcand <= ACC_W'(lx);
          mpl <= MPL_W'(cos_v);
          mcnt <= '0;
          ret <= ST_ROT2;
          state <= ST_MUL;
        end
        ST_ROT2: begin
          mcand <= ACC_W'(ly);
          mpl <= MPL_W'(sin_v);
          mcnt <= '0;
          ret <= ST_ROT3;
          state <= ST_MUL;
        end
        ST_ROT3: begin
          vx_raw <= fmeas[31] ? 34'(lx) : acc[47:14];
          acc <= '0;
          mcand <= ACC_W'(ly);
          mpl <= MPL_W'(cos_v);
          mcnt <= '0;
          ret <= ST_ROT4;
          state <= ST_MUL;
        end
        ST_ROT4: begin
          mcand <= -ACC_W'(lx);
          mpl <= MPL_W'(sin_v);
          mcnt <= '0;
          ret <= ST_OUT;
          state <= ST_MUL;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            vel_x <= clamp_lim(vx_raw, limits[15:0]);
            vel_y <= clamp_lim(vy_raw, limits[15:0]);
            vel_z <= clamp_lim(34'(lz), limits[31:16]);
            fmode_q <= fmeas[31];
            hold_q <= hold;
            m_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign vz_ok = ($signed(m_tdata[95:64]) <= $signed({8'd0, limits[31:16], 8'd0})) &&
                 ($signed(m_tdata[95:64]) >= -$signed({8'd0, limits[31:16], 8'd0}));

  `CHK_NEXT(a_one_tick, s_tvalid && s_tready, !s_tready, "second request taken while busy")
  `CHK_IMPL(a_div_rem, state == ST_DIV, rem < dsr, "divider remainder out of range")
  `CHK_IMPL(a_z_clamp, m_tvalid, vz_ok, "z command outside configured limit")

endmodule
